// ----- rtl/dtq_pkg.sv -----
package dtq_pkg;

    // Opcodes of an input item
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_POP    = 3'd2;
    localparam logic [2:0] OP_PEEK   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int ID_W    = 16;
    localparam int DELTA_W = 32;

    // One queue entry as held in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [DELTA_W-1:0] delta;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- rtl/dtq_ram.sv -----
module dtq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/delta_timer_queue.sv -----
// Channel | direction | handshake                | payload
// input   | in        | i_in_valid / o_in_stall  | i_opcode, i_entry_id, i_time_value
// output  | out       | o_out_valid / i_out_stall| o_status, o_out_id, o_out_delta,
//         |           |                          | o_queue_count
// One item at a time. Entries sit in slot memory in queue order, head at slot 0.
// Each slot visited takes a memory read, then an evaluate and write-back step.
// Reset is synchronous and empties the queue at once; no clearing pass.
// A stalled result waits in the output register while the next item is taken.
module delta_timer_queue
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_opcode,
    input  logic [ID_W-1:0]      i_entry_id,
    input  logic [DELTA_W-1:0]   i_time_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [ID_W-1:0]      o_out_id,
    output logic [DELTA_W-1:0]   o_out_delta,
    output logic [4:0]           o_queue_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SH_RD, S_SH_EV,
        S_LOC_RD, S_LOC_EV, S_CL_RD, S_CL_EV, S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_ovalid, n_ovalid;
    logic [2:0]         r_op, n_op;
    logic [ID_W-1:0]    r_id, n_id;
    logic [DELTA_W-1:0] r_t, n_t;
    t_entry             r_carry, n_carry;
    logic               r_head, n_head;
    logic               r_first, n_first;
    logic [1:0]         r_status, n_status;
    logic [ID_W-1:0]    r_rid, n_rid;
    logic [DELTA_W-1:0] r_rdelta, n_rdelta;
    logic [1:0]         n_o_status;
    logic [ID_W-1:0]    n_o_id;
    logic [DELTA_W-1:0] n_o_delta;
    logic [4:0]         n_o_count;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    t_entry             ram_wdata, rd;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [DELTA_W:0]   sat_sum;

    dtq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd         = t_entry'(ram_rdata);
    assign sat_sum    = {1'b0, rd.delta} + {1'b0, r_rdelta};
    assign o_in_stall = (r_state != S_IDLE);

    // Sequence the walk over the slots
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_ovalid   = r_ovalid;
        n_op       = r_op;
        n_id       = r_id;
        n_t        = r_t;
        n_carry    = r_carry;
        n_head     = r_head;
        n_first    = r_first;
        n_status   = r_status;
        n_rid      = r_rid;
        n_rdelta   = r_rdelta;
        n_o_status = o_status;
        n_o_id     = o_out_id;
        n_o_delta  = o_out_delta;
        n_o_count  = o_queue_count;
        ram_we     = 1'b0;
        ram_waddr  = r_pos[AW-1:0];
        ram_wdata  = r_carry;
        ram_raddr  = r_pos[AW-1:0];

        // Drop a result once taken
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_id     = i_entry_id;
                    n_t      = i_time_value;
                    n_pos    = '0;
                    n_status = ST_OK;
                    n_rid    = '0;
                    n_rdelta = '0;
                    n_head   = 1'b0;
                    n_first  = 1'b0;
                    case (i_opcode)
                        OP_INSERT: begin
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_REMOVE, OP_FIND: n_state = S_LOC_RD;
                        OP_POP, OP_PEEK: begin
                            n_head  = 1'b1;
                            n_state = S_LOC_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_pos == r_count) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{ident: r_id, delta: r_t};
                    n_rid     = r_id;
                    n_rdelta  = r_t;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end else begin
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                if (rd.delta <= r_t) begin
                    // Advance past an entry due no later
                    n_t     = r_t - rd.delta;
                    n_pos   = r_pos + CW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    // Place the new entry, carry the successor with its reduced delta
                    ram_we    = 1'b1;
                    ram_wdata = '{ident: r_id, delta: r_t};
                    n_carry   = '{ident: rd.ident, delta: rd.delta - r_t};
                    n_rid     = r_id;
                    n_rdelta  = r_t;
                    n_pos     = r_pos + CW'(1);
                    n_state   = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (r_pos == r_count) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SH_EV;
                end
            end
            S_SH_EV: begin
                // Shift one entry back
                ram_we  = 1'b1;
                n_carry = rd;
                n_pos   = r_pos + CW'(1);
                n_state = S_SH_RD;
            end
            S_LOC_RD: begin
                if (r_pos == r_count) begin
                    n_status = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_LOC_EV;
                end
            end
            S_LOC_EV: begin
                if (r_head || rd.ident == r_id) begin
                    n_rid    = rd.ident;
                    n_rdelta = rd.delta;
                    if (r_op == OP_FIND || r_op == OP_PEEK) begin
                        n_state = S_DONE;
                    end else begin
                        n_first = (r_op == OP_REMOVE);
                        n_state = S_CL_RD;
                    end
                end else begin
                    n_pos   = r_pos + CW'(1);
                    n_state = S_LOC_RD;
                end
            end
            S_CL_RD: begin
                ram_raddr = AW'(r_pos + CW'(1));
                if (r_pos + CW'(1) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_CL_EV;
                end
            end
            S_CL_EV: begin
                // Move one entry forward; on a remove the first one absorbs the removed delta
                ram_we    = 1'b1;
                ram_wdata = rd;
                if (r_first) begin
                    ram_wdata.delta = sat_sum[DELTA_W] ? '1 : sat_sum[DELTA_W-1:0];
                end
                n_first = 1'b0;
                n_pos   = r_pos + CW'(1);
                n_state = S_CL_RD;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_id     = r_rid;
                    n_o_delta  = r_rdelta;
                    n_o_count  = 5'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_pos         <= n_pos;
        r_op          <= n_op;
        r_id          <= n_id;
        r_t           <= n_t;
        r_carry       <= n_carry;
        r_head        <= n_head;
        r_first       <= n_first;
        r_status      <= n_status;
        r_rid         <= n_rid;
        r_rdelta      <= n_rdelta;
        o_status      <= n_o_status;
        o_out_id      <= n_o_id;
        o_out_delta   <= n_o_delta;
        o_queue_count <= n_o_count;
    end

    assign o_out_valid = r_ovalid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)
             || r_count + CW'(1) == $past(r_count)))
        else $error("entry count moved by more than one");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> o_queue_count == 5'(QUEUE_DEPTH))
        else $error("full status with spare slots");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL))
        else $error("undefined status code");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import dtq_pkg::*;

    localparam int DEPTH = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_opcode;
    logic [ID_W-1:0]    i_entry_id;
    logic [DELTA_W-1:0] i_time_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_status;
    logic [ID_W-1:0]    o_out_id;
    logic [DELTA_W-1:0] o_out_delta;
    logic [4:0]         o_queue_count;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    ident;
        logic [DELTA_W-1:0] delta;
        logic [4:0]         count;
    } t_answer;

    // Shadow copy of the queue, head at index 0
    logic [ID_W-1:0]    q_ident [DEPTH];
    logic [DELTA_W-1:0] q_delta [DEPTH];
    int                 q_len;

    t_answer answers_due[$];
    int      mismatches;
    bit      out_stall_busy;

    delta_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int locate_id(logic [ID_W-1:0] id);
        int i;
        for (i = 0; i < q_len; i++)
            if (q_ident[i] == id) return i;
        return q_len;
    endfunction

    function automatic void close_slot(int pos);
        int i;
        for (i = pos; i + 1 < q_len; i++) begin
            q_ident[i] = q_ident[i + 1];
            q_delta[i] = q_delta[i + 1];
        end
        q_len--;
    endfunction

    // Work out the answer to one operation and advance the shadow queue
    function automatic t_answer apply_op(logic [2:0] op, logic [ID_W-1:0] id,
                                         logic [DELTA_W-1:0] tv);
        t_answer a;
        int pos, i;
        logic [DELTA_W-1:0] t;
        logic [DELTA_W:0] sum;
        a = '0;
        t = tv;
        case (op)
            OP_INSERT: begin
                if (q_len >= DEPTH) begin
                    a.status = ST_FULL;
                end else begin
                    pos = 0;
                    if (q_len > 0 && t >= q_delta[0]) begin
                        do begin
                            t = t - q_delta[pos];
                            pos++;
                        end while (pos < q_len && q_delta[pos] <= t);
                    end
                    if (pos < q_len) q_delta[pos] = q_delta[pos] - t;
                    for (i = q_len; i > pos; i--) begin
                        q_ident[i] = q_ident[i - 1];
                        q_delta[i] = q_delta[i - 1];
                    end
                    q_len++;
                    q_ident[pos] = id;
                    q_delta[pos] = t;
                    a.ident = id;
                    a.delta = t;
                end
            end
            OP_REMOVE: begin
                pos = locate_id(id);
                if (pos >= q_len) begin
                    a.status = ST_MISS;
                end else begin
                    a.ident = q_ident[pos];
                    a.delta = q_delta[pos];
                    if (pos + 1 < q_len) begin
                        sum = {1'b0, q_delta[pos + 1]} + {1'b0, a.delta};
                        q_delta[pos + 1] = sum[DELTA_W] ? '1 : sum[DELTA_W-1:0];
                    end
                    close_slot(pos);
                end
            end
            OP_POP, OP_PEEK: begin
                if (q_len == 0) begin
                    a.status = ST_MISS;
                end else begin
                    a.ident = q_ident[0];
                    a.delta = q_delta[0];
                    if (op == OP_POP) close_slot(0);
                end
            end
            OP_FIND: begin
                pos = locate_id(id);
                if (pos >= q_len) begin
                    a.status = ST_MISS;
                end else begin
                    a.ident = q_ident[pos];
                    a.delta = q_delta[pos];
                end
            end
            default: ;
        endcase
        a.count = 5'(q_len);
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Send one item and record its expected answer; valid stays high when
    // the next item follows with no gap
    task automatic send_op(logic [2:0] op, logic [ID_W-1:0] id, logic [DELTA_W-1:0] tv);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_opcode     <= op;
        i_entry_id   <= id;
        i_time_value <= tv;
        i_in_valid   <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        answers_due.push_back(apply_op(op, id, tv));
        @(negedge i_clk);
    endtask

    // Check each accepted result against the oldest answer
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                w = answers_due.pop_front();
                if (o_status != w.status) report_mismatch("status", o_status, w.status);
                if (o_out_id != w.ident) report_mismatch("out_id", o_out_id, w.ident);
                if (o_out_delta != w.delta)
                    report_mismatch("out_delta", o_out_delta, w.delta);
                if (o_queue_count != w.count)
                    report_mismatch("queue_count", o_queue_count, w.count);
            end
        end
    end

    // Stall the result channel at random while out_stall_busy is set, with quiet stretches
    initial begin
        int g;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            g = out_stall_busy ? gap_len() : 0;
            if (g != 0) begin
                i_out_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [DELTA_W-1:0] rand_delay();
        case ($urandom_range(0, 5))
            0: return '1 - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            2: return $urandom();
            default: return $urandom_range(0, 200);
        endcase
    endfunction

    task automatic test_directed();
        int i;
        // empty queue misses, then unknown opcodes
        send_op(OP_POP, 16'h0001, '0);
        send_op(OP_PEEK, 16'h0001, '1);
        send_op(OP_REMOVE, 16'hFFFF, '0);
        send_op(OP_FIND, 16'h0000, '0);
        send_op(3'd5, 16'hFFFF, '1);
        send_op(3'd7, 16'h0000, '0);
        // equal due times and duplicate ids
        send_op(OP_INSERT, 16'h0000, 32'd10);
        send_op(OP_INSERT, 16'hFFFF, 32'd10);
        send_op(OP_INSERT, 16'hFFFF, 32'd0);
        send_op(OP_INSERT, 16'h0007, 32'hFFFF_FFFF);
        send_op(OP_FIND, 16'hFFFF, '0);
        send_op(OP_PEEK, 16'h0000, '0);
        // remove passes a large delta on to its successor
        send_op(OP_INSERT, 16'h0008, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 16'h0007, '0);
        // fill to the limit and refuse one more
        for (i = 0; i < DEPTH - 4; i++) send_op(OP_INSERT, 16'(i + 32), 32'(i * 3));
        send_op(OP_INSERT, 16'h1234, 32'd5);
        send_op(OP_POP, 16'h0000, '0);
        send_op(OP_REMOVE, 16'h0008, '0);
    endtask

    task automatic test_random(int n);
        int i;
        int r;
        logic [ID_W-1:0] id;
        for (i = 0; i < n; i++) begin
            // mostly ids from a small pool so remove and find hit
            id = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 23)) : 16'($urandom());
            r = $urandom_range(0, 99);
            if (r < 40) send_op(OP_INSERT, id, rand_delay());
            else if (r < 58) send_op(OP_REMOVE, id, $urandom());
            else if (r < 72) send_op(OP_POP, id, $urandom());
            else if (r < 82) send_op(OP_PEEK, id, $urandom());
            else if (r < 97) send_op(OP_FIND, id, $urandom());
            else send_op(3'($urandom_range(5, 7)), id, $urandom());
        end
    endtask

    initial begin
        int waited;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = '0;
        i_entry_id   = '0;
        i_time_value = '0;
        q_len        = 0;
        mismatches   = 0;
        out_stall_busy = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        out_stall_busy = 1'b1;
        test_random(700);
        out_stall_busy = 1'b0;
        test_random(330);
        i_in_valid <= 1'b0;
        // drain remaining results
        waited = 0;
        while (answers_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
